// ===== sv/lpbm_pkg.sv =====
// Shared types and codes for the LRU page buffer manager.
package lpbm_pkg;

    typedef enum logic [2:0] {
        OP_GET       = 3'd0,
        OP_PIN       = 3'd1,
        OP_UNPIN     = 3'd2,
        OP_UNPIN_ALL = 3'd3,
        OP_DIRTY     = 3'd4,
        OP_FLUSH     = 3'd5,
        OP_RSVD6     = 3'd6,
        OP_RSVD7     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ALL_PINNED = 2'd1,
        ST_RANGE      = 2'd2,
        ST_RSVD       = 2'd3
    } t_status;

    localparam logic CFG_FRAME_LIMIT = 1'b0;
    localparam logic CFG_INIT_PAGES  = 1'b1;

    localparam int FL_W     = 7;
    localparam int PC_W     = 16;
    localparam int CLOCK_W  = 32;
    localparam int PG_W     = 6;
    localparam logic [FL_W-1:0] FRAME_LIMIT_RST = 7'd16;

    typedef struct packed {
        logic [2:0]      opcode;
        logic [PG_W-1:0] page_index;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic            hit;
        logic            fetch_from_store;
        logic            evicted;
        logic [PG_W-1:0] evicted_page;
        logic            write_back;
        logic [PG_W-1:0] write_back_page;
    } t_result;

    typedef struct packed {
        logic load;
        logic rd;
        logic exec;
        logic scan;
        logic vic;
        logic fill;
    } t_ctl;

    typedef struct packed {
        logic imm;
        logic miss;
        logic full;
        logic scan_done;
        logic found;
    } t_sts;

endpackage

// ===== sv/lru_page_buffer_manager.sv =====
// Top level of the LRU page buffer manager.
//  channel   | signals                                   | handshake
//  request   | i_start, o_busy, i_req                    | accepted when i_start && !o_busy
//  result    | o_result_valid, o_result                  | one-cycle strobe, no back-pressure
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index/data| written when valid && ready
// Unpin-all, reserved opcodes and range errors: result in the cycle after accept.
// Hits and other opcodes: S_RD, S_EXEC. Miss below the frame limit: then S_FILL.
// Miss at the frame limit: one-entry-a-cycle victim scan, S_VIC, S_FILL if found.
// Synchronous active-low reset; no clearing pass. Results cannot be stalled.
module lru_page_buffer_manager import lpbm_pkg::*; #(
    parameter int N_SLOTS   = 64,
    parameter int PIN_WIDTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  t_req            i_req,
    output logic            o_result_valid,
    output t_result         o_result,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  logic [PC_W-1:0] i_cfg_data
);
    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = !o_busy;

    lpbm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (o_busy)
    );

    lpbm_dp #(.N_SLOTS(N_SLOTS), .PIN_WIDTH(PIN_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_req          (i_req),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );
endmodule

// ===== sv/lpbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpbm_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/lpbm_ctrl.sv =====
// Sequencer for the page buffer manager.
module lpbm_ctrl import lpbm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_busy
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_EXEC = 6'b000100,
        S_SCAN = 6'b001000,
        S_VIC  = 6'b010000,
        S_FILL = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = i_sts.imm ? S_IDLE : S_RD;
                end
            end
            S_RD: begin
                o_ctl.rd = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                if (i_sts.miss) begin
                    n_state = i_sts.full ? S_SCAN : S_FILL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_VIC;
                end
            end
            S_VIC: begin
                o_ctl.vic = 1'b1;
                n_state   = i_sts.found ? S_FILL : S_IDLE;
            end
            S_FILL: begin
                o_ctl.fill = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ===== sv/lpbm_dp.sv =====
// Page metadata, victim scan and result register.
module lpbm_dp import lpbm_pkg::*; #(
    parameter int N_SLOTS   = 64,
    parameter int PIN_WIDTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ctl            i_ctl,
    input  t_req            i_req,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [PC_W-1:0] i_cfg_data,
    output t_sts            o_sts,
    output logic            o_result_valid,
    output t_result         o_result
);
    localparam int PW = $clog2(N_SLOTS);
    localparam int CW = (PW + 1 > FL_W) ? PW + 1 : FL_W;
    localparam logic [PW:0] NP = (PW+1)'(N_SLOTS);
    localparam logic [PIN_WIDTH-1:0] PIN_MAX = '1;

    logic [N_SLOTS-1:0]   r_res, r_dirty, r_pvalid;
    logic [PW:0]          r_count;
    logic [CLOCK_W-1:0]   r_clock;
    logic [PC_W-1:0]      r_store;
    logic [FL_W-1:0]      r_flimit;
    t_req                 r_req;
    logic [PIN_WIDTH-1:0] r_pcur;
    logic [PW:0]          r_sidx;
    logic                 r_cval;
    logic [PW-1:0]        r_cidx;
    logic                 r_found;
    logic [PW-1:0]        r_victim;
    logic [CLOCK_W-1:0]   r_oldest;
    logic                 r_strobe;
    t_result              r_out;

    logic [PW-1:0]        pgx, raddr;
    logic [PIN_WIDTH-1:0] pin_rd, pcur, pcur_sel, pin_inc, pin_wdata;
    logic [CLOCK_W-1:0]   lu_rd, clock_nx;
    logic                 pin_we, lu_we, is_miss, cmp_pin0, take;
    logic [FL_W-1:0]      limit;
    logic                 range_err;
    t_op                  req_op, cur_op;

    assign req_op    = t_op'(i_req.opcode);
    assign cur_op    = t_op'(r_req.opcode);
    assign range_err = ({{(32-PG_W){1'b0}}, i_req.page_index} >= 32'(N_SLOTS));
    assign pgx       = PW'(r_req.page_index);
    assign raddr     = i_ctl.scan ? r_sidx[PW-1:0] : pgx;
    assign limit     = (r_flimit == '0) ? FL_W'(1) : r_flimit;
    assign is_miss   = (cur_op == OP_GET) && !r_res[pgx];
    assign clock_nx  = r_clock + CLOCK_W'(1);

    assign pcur     = r_pvalid[pgx] ? pin_rd : '0;
    assign pcur_sel = i_ctl.fill ? r_pcur : pcur;
    assign pin_inc  = (pcur_sel == PIN_MAX) ? pcur_sel : pcur_sel + PIN_WIDTH'(1);

    always_comb begin
        pin_we    = 1'b0;
        pin_wdata = pin_inc;
        lu_we     = 1'b0;
        if (i_ctl.exec) begin
            unique case (cur_op)
                OP_GET: begin
                    pin_we = !is_miss;
                    lu_we  = !is_miss;
                end
                OP_PIN:   pin_we = 1'b1;
                OP_UNPIN: begin
                    pin_we    = 1'b1;
                    pin_wdata = (pcur == '0) ? pcur : pcur - PIN_WIDTH'(1);
                end
                default: pin_we = 1'b0;
            endcase
        end else if (i_ctl.fill) begin
            pin_we = 1'b1;
            lu_we  = 1'b1;
        end
    end

    assign cmp_pin0 = r_pvalid[r_cidx] ? (pin_rd == '0) : 1'b1;
    assign take     = r_cval && r_res[r_cidx] && cmp_pin0 && (!r_found || lu_rd < r_oldest);

    lpbm_ram #(.W(PIN_WIDTH), .D(N_SLOTS)) u_pin_ram (
        .i_clk   (i_clk),
        .i_we    (pin_we),
        .i_waddr (pgx),
        .i_wdata (pin_wdata),
        .i_raddr (raddr),
        .o_rdata (pin_rd)
    );

    lpbm_ram #(.W(CLOCK_W), .D(N_SLOTS)) u_lu_ram (
        .i_clk   (i_clk),
        .i_we    (lu_we),
        .i_waddr (pgx),
        .i_wdata (clock_nx),
        .i_raddr (raddr),
        .o_rdata (lu_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res    <= '0;
            r_dirty  <= '0;
            r_pvalid <= '0;
            r_count  <= '0;
            r_clock  <= '0;
            r_store  <= '0;
            r_flimit <= FRAME_LIMIT_RST;
            r_strobe <= 1'b0;
            r_cval   <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_LIMIT: r_flimit <= i_cfg_data[FL_W-1:0];
                    CFG_INIT_PAGES:  r_store  <= i_cfg_data;
                    default:         r_store  <= r_store;
                endcase
            end
            if (i_ctl.load) begin
                r_req <= i_req;
                r_out <= '0;
                if (req_op == OP_UNPIN_ALL) begin
                    r_pvalid <= '0;
                end
                if (o_sts.imm) begin
                    r_strobe <= 1'b1;
                    if (req_op != OP_UNPIN_ALL && req_op != OP_RSVD6 &&
                        req_op != OP_RSVD7) begin
                        r_out.status <= ST_RANGE;
                    end
                end
            end
            if (pin_we) begin
                r_pvalid[pgx] <= 1'b1;
            end
            if (lu_we) begin
                r_clock <= clock_nx;
            end
            if (i_ctl.exec) begin
                r_pcur  <= pcur;
                r_sidx  <= '0;
                r_cval  <= 1'b0;
                r_found <= 1'b0;
                if (!is_miss) begin
                    r_strobe <= 1'b1;
                end
                unique case (cur_op)
                    OP_GET:   r_out.hit <= !is_miss;
                    OP_DIRTY: r_dirty[pgx] <= 1'b1;
                    OP_FLUSH: begin
                        if (r_res[pgx] && r_dirty[pgx]) begin
                            r_out.write_back      <= 1'b1;
                            r_out.write_back_page <= r_req.page_index;
                            r_dirty[pgx]          <= 1'b0;
                        end
                    end
                    default: r_out.hit <= 1'b0;
                endcase
            end
            if (i_ctl.scan) begin
                r_cval <= (r_sidx != NP);
                r_cidx <= r_sidx[PW-1:0];
                if (r_sidx != NP) begin
                    r_sidx <= r_sidx + (PW+1)'(1);
                end
                if (take) begin
                    r_found  <= 1'b1;
                    r_victim <= r_cidx;
                    r_oldest <= lu_rd;
                end
            end
            if (i_ctl.vic) begin
                if (r_found) begin
                    r_res[r_victim]    <= 1'b0;
                    r_dirty[r_victim]  <= 1'b0;
                    r_count            <= r_count - (PW+1)'(1);
                    r_out.evicted      <= 1'b1;
                    r_out.evicted_page <= PG_W'(r_victim);
                    if (r_dirty[r_victim]) begin
                        r_out.write_back      <= 1'b1;
                        r_out.write_back_page <= PG_W'(r_victim);
                    end
                end else begin
                    r_out.status <= ST_ALL_PINNED;
                    r_strobe     <= 1'b1;
                end
            end
            if (i_ctl.fill) begin
                r_res[pgx]   <= 1'b1;
                r_dirty[pgx] <= 1'b0;
                r_count      <= r_count + (PW+1)'(1);
                r_strobe     <= 1'b1;
                if (PC_W'(r_req.page_index) < r_store) begin
                    r_out.fetch_from_store <= 1'b1;
                end else begin
                    r_store <= PC_W'(r_req.page_index) + PC_W'(1);
                end
            end
        end
    end

    assign o_sts.imm       = (req_op == OP_UNPIN_ALL) || (req_op == OP_RSVD6) ||
                             (req_op == OP_RSVD7) || range_err;
    assign o_sts.miss      = is_miss;
    assign o_sts.full      = (CW'(r_count) >= CW'(limit));
    assign o_sts.scan_done = (r_sidx == NP) && r_cval;
    assign o_sts.found     = r_found;

    assign o_result_valid = r_strobe;
    assign o_result       = r_out;
endmodule

// ===== sv/lpbm_chk.sv =====
// Port-level checker for the LRU page buffer manager, bound to the top level.
module lpbm_chk import lpbm_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_start,
    input logic    o_busy,
    input logic    o_result_valid,
    input t_result o_result
);
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy || o_result_valid)
        else $error("request accepted but nothing followed");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !o_busy)
        else $error("result shown while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_result.status != ST_RSVD)
        else $error("bad status code");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status != ST_OK |->
        !o_result.hit && !o_result.evicted && !o_result.write_back)
        else $error("error result carries flags");

    a_wb_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.evicted && o_result.write_back |->
        o_result.write_back_page == o_result.evicted_page)
        else $error("write-back page differs from victim");
endmodule

bind lru_page_buffer_manager lpbm_chk u_lpbm_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
